// ===== design/indexed_min_heap_decrease_key_defines.svh =====
// assertion macros for the indexed min-heap block
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH
// implication checked on every clock edge outside reset
`define IMH_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define IMH_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// ===== design/imh_pkg.sv =====
// package: widths, codes, states and helpers of the indexed min-heap
package imh_pkg;
	localparam int NODE_COUNT = 256;
	localparam int IW = $clog2(NODE_COUNT);
	localparam int CW = 32;
	localparam logic [CW-1:0] COST_INF = '1;
	localparam logic [IW-1:0] LAST_SLOT = IW'(NODE_COUNT - 1);

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_DEC   = 2'd1,
		MODE_REM   = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLR, ST_DK_RD, ST_DK_CHK, ST_UP_RD, ST_UP_CMP,
		ST_RM_RD, ST_RM_MOVE, ST_DN_RD, ST_DN_LEFT, ST_DN_PICK, ST_DN_CMP, ST_SWAP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [IW-1:0] node;
		logic [CW-1:0] cost;
	} slot_t;

	// saturating add of margin
	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [7:0] m);
		logic [CW:0] s;
		s = {1'b0, a} + {{(CW-7){1'b0}}, m};
		return s[CW] ? COST_INF : s[CW-1:0];
	endfunction
endpackage

// ===== design/imh_if.sv =====
// valid/ready channel carrying a struct payload
interface imh_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/imh_cmp.sv =====
// shared compare unit: a >= sat(b + margin)
module imh_cmp import imh_pkg::*; (
	input  logic [CW-1:0] a,
	input  logic [CW-1:0] b,
	input  logic [7:0]    margin,
	output logic          ge
);
	assign ge = a >= sat_add(b, margin);
endmodule

// ===== design/indexed_min_heap_decrease_key.sv =====
// indexed min-heap with decrease-key and remove-first, one shared comparator
//
// in: valid/ready channel with mode, node_id and new_cost. out: valid/ready
// channel with removed_node, removed_cost, heap_empty, rejected; one result
// item per input item. cfg_we/cfg_wdata write tie_margin (reset 1).
// The heap lives in two memories (slots and positions), one read per
// cycle each, with registered reads. A single comparator is stepped by the
// sequencer.
// clear writes one slot per cycle; mode 3 goes straight to the result;
// decrease-key ends without climbing when rejected or already at the root,
// else climbs one level per swap; remove-first moves the last slot to the root
// and descends one level per swap until it stops or ends in a leaf. the
// sequencer returns to idle between items.
// in.ready is high whenever the sequencer is idle; a result waiting in the
// output register holds the sequencer in its last state, so a stalled
// receiver blocks only the item after the one in progress.
// after reset the memories are swept one entry per cycle to
// slot i = node i with infinite cost before the first item is taken.
module indexed_min_heap_decrease_key import imh_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic [7:0] cfg_wdata,
	imh_if.sink    in,
	imh_if.source  out
);
	`include "indexed_min_heap_decrease_key_defines.svh"

	state_t st_q, st_d;
	slot_t heap_mem [NODE_COUNT];
	logic [IW-1:0] pos_mem [NODE_COUNT];
	logic [7:0] margin_q;
	logic [IW:0] cnt_q;
	logic [1:0] mode_q;
	logic [IW-1:0] nid_q;
	logic [CW-1:0] ncost_q;
	logic [IW-1:0] cur_q, oth_q;
	slot_t cur_s_q, oth_s_q, rd_q, first_q;
	logic [IW-1:0] pos_rd_q;
	logic rej_q, sub_q;
	logic [CW-1:0] root_cost_q;
	logic [CW-1:0] ca, cb;
	logic ge;
	logic ovalid_q;
	logic init_q, done_fire;
	logic [IW-1:0] ro_node_q; logic [CW-1:0] ro_cost_q; logic ro_emp_q, ro_rej_q;

	// memory port controls
	logic h_we, p_we; logic [IW-1:0] h_wa, h_ra, p_wa, p_ra; slot_t h_wd; logic [IW-1:0] p_wd;
	logic h_we2, p_we2; logic [IW-1:0] h_wa2, p_wa2; slot_t h_wd2; logic [IW-1:0] p_wd2;

	imh_cmp u_cmp (.a(ca), .b(cb), .margin(margin_q), .ge(ge));

	always_ff @(posedge clk) begin
		if (h_we) heap_mem[h_wa] <= h_wd;
		if (h_we2) heap_mem[h_wa2] <= h_wd2;
		rd_q <= heap_mem[h_ra];
	end
	always_ff @(posedge clk) begin
		if (p_we) pos_mem[p_wa] <= p_wd;
		if (p_we2) pos_mem[p_wa2] <= p_wd2;
		pos_rd_q <= pos_mem[p_ra];
	end

	wire [IW:0] lchild = {cur_q, 1'b1};
	wire lvalid = lchild < (IW+1)'(NODE_COUNT);
	wire rvalid = (lchild + 1'b1) < (IW+1)'(NODE_COUNT);
	wire [IW-1:0] parent = IW'(({1'b0, cur_q} + 1'b1) / 2 - 1'b1);

	// the result register takes a new item once the old one is gone
	assign done_fire = (st_q == ST_DONE) && (!ovalid_q || out.ready);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in.valid && in.ready) begin
				unique case (mode_t'(in.data.mode))
					MODE_CLEAR: st_d = ST_CLR;
					MODE_DEC: st_d = ST_DK_RD;
					MODE_REM: st_d = ST_RM_RD;
					default: st_d = ST_DONE;
				endcase
			end
			ST_CLR: if (cnt_q == (IW+1)'(NODE_COUNT - 1)) st_d = ST_DONE;
			ST_DK_RD: st_d = ST_DK_CHK;
			ST_DK_CHK: st_d = ST_UP_RD;
			ST_UP_RD: st_d = ST_UP_CMP;
			ST_UP_CMP: st_d = ST_DONE;
			ST_RM_RD: st_d = ST_RM_MOVE;
			ST_RM_MOVE: st_d = ST_DN_RD;
			ST_DN_RD: st_d = ST_DN_LEFT;
			ST_DN_LEFT: st_d = ST_DN_PICK;
			ST_DN_PICK: st_d = ST_DN_CMP;
			ST_DN_CMP: st_d = ST_DONE;
			ST_SWAP: st_d = sub_q ? ST_DN_RD : ST_UP_RD;
			ST_DONE: st_d = done_fire ? ST_IDLE : ST_DONE;
			default: st_d = ST_IDLE;
		endcase
		// data-dependent branches
		if (st_q == ST_DK_RD) st_d = ST_DK_CHK;
		if (st_q == ST_DK_CHK && (!ge || cur_q == '0)) st_d = ST_DONE;
		if (st_q == ST_UP_RD) st_d = ST_UP_CMP;
		if (st_q == ST_UP_CMP) st_d = ge ? ST_SWAP : ST_DONE;
		if (st_q == ST_RM_MOVE) st_d = lvalid ? ST_DN_RD : ST_DONE;
		if (st_q == ST_DN_LEFT) st_d = rvalid ? ST_DN_PICK : ST_DN_CMP;
		if (st_q == ST_DN_CMP) st_d = ge ? ST_SWAP : ST_DONE;
		if (st_q == ST_SWAP && sub_q && !(({oth_q, 1'b1}) < (IW+1)'(NODE_COUNT)))
			st_d = ST_DONE;
		if (st_q == ST_SWAP && !sub_q && oth_q == '0) st_d = ST_DONE;
	end

	always_comb begin
		h_we = 1'b0; h_wa = cur_q; h_wd = cur_s_q; h_ra = cur_q;
		h_we2 = 1'b0; h_wa2 = oth_q; h_wd2 = oth_s_q;
		p_we = 1'b0; p_wa = cur_s_q.node; p_wd = cur_q; p_ra = nid_q;
		p_we2 = 1'b0; p_wa2 = oth_s_q.node; p_wd2 = oth_q;
		ca = cur_s_q.cost; cb = rd_q.cost;
		unique case (st_q)
			// root and node position are read while the item is accepted
			ST_IDLE: begin h_ra = '0; p_ra = in.data.node_id; end
			ST_CLR: begin
				h_we = 1'b1; h_wa = cnt_q[IW-1:0];
				h_wd = '{node: cnt_q[IW-1:0], cost: COST_INF};
				p_we = 1'b1; p_wa = cnt_q[IW-1:0]; p_wd = cnt_q[IW-1:0];
			end
			ST_DK_RD: h_ra = pos_rd_q;
			ST_DK_CHK: begin
				// rd_q is the slot at the node's position
				ca = rd_q.cost; cb = ncost_q;
				h_we = ge; h_wa = cur_q; h_wd = '{node: rd_q.node, cost: ncost_q};
			end
			ST_UP_RD: h_ra = parent;
			ST_UP_CMP: begin ca = rd_q.cost; cb = cur_s_q.cost; end
			ST_RM_RD: h_ra = LAST_SLOT;
			ST_RM_MOVE: begin
				h_we = 1'b1; h_wa = '0; h_wd = rd_q;
				h_we2 = 1'b1; h_wa2 = LAST_SLOT; h_wd2 = '{node: first_q.node, cost: COST_INF};
				p_we = 1'b1; p_wa = rd_q.node; p_wd = '0;
				p_we2 = 1'b1; p_wa2 = first_q.node; p_wd2 = LAST_SLOT;
			end
			ST_DN_RD: h_ra = lchild[IW-1:0];
			ST_DN_LEFT: h_ra = IW'(lchild + 1'b1);
			ST_DN_CMP: begin ca = cur_s_q.cost; cb = oth_s_q.cost; end
			ST_SWAP: begin
				h_we = 1'b1; h_wa = cur_q; h_wd = oth_s_q;
				h_we2 = 1'b1; h_wa2 = oth_q; h_wd2 = cur_s_q;
				p_we = 1'b1; p_wa = oth_s_q.node; p_wd = cur_q;
				p_we2 = 1'b1; p_wa2 = cur_s_q.node; p_wd2 = oth_q;
			end
			default: ;
		endcase
		if (st_q == ST_DN_PICK) begin
			// left child in oth_s_q, right in rd_q: choose right when left >= sat(right+m)
			ca = oth_s_q.cost; cb = rd_q.cost;
		end
	end

	assign in.ready = (st_q == ST_IDLE) && init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; cnt_q <= '0; margin_q <= 8'd1; ovalid_q <= 1'b0;
			init_q <= 1'b0; mode_q <= MODE_NONE;
		end else begin
			st_q <= st_d;
			if (cfg_we) margin_q <= cfg_wdata;
			if (st_q == ST_CLR) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			if (in.valid && in.ready) mode_q <= in.data.mode;
			if (done_fire && init_q) ovalid_q <= 1'b1;
			else if (out.valid && out.ready) ovalid_q <= 1'b0;
			if (st_q == ST_DONE) init_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				nid_q <= in.data.node_id; ncost_q <= in.data.new_cost;
				rej_q <= 1'b0; sub_q <= 1'b0; cur_q <= '0;
			end
			ST_DK_RD: cur_q <= pos_rd_q;
			ST_DK_CHK: begin
				rej_q <= !ge;
				cur_s_q <= '{node: rd_q.node, cost: ncost_q};
			end
			ST_UP_RD: oth_q <= parent;
			ST_UP_CMP: oth_s_q <= rd_q;
			ST_RM_RD: begin first_q <= rd_q; sub_q <= 1'b1; cur_q <= '0; end
			ST_RM_MOVE: cur_s_q <= rd_q;
			ST_DN_RD: oth_q <= lchild[IW-1:0];
			ST_DN_LEFT: oth_s_q <= rd_q;
			ST_DN_PICK: if (ge) begin
				oth_s_q <= rd_q;
				oth_q <= IW'(lchild + 1'b1);
			end
			ST_SWAP: cur_q <= oth_q;
			default: ;
		endcase
		if (done_fire) begin
			ro_node_q <= (mode_q == MODE_REM) ? first_q.node : '0;
			ro_cost_q <= (mode_q == MODE_REM) ? first_q.cost : '0;
			ro_rej_q <= (mode_q == MODE_DEC) && rej_q;
			ro_emp_q <= root_cost_q == COST_INF;
		end
	end

	// root cost tracker, kept in step with every write to slot zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) root_cost_q <= COST_INF;
		else if (h_we && h_wa == '0) root_cost_q <= h_wd.cost;
		else if (h_we2 && h_wa2 == '0) root_cost_q <= h_wd2.cost;
	end

	// root and position reads are issued while idle so they land in the first busy state
	assign out.valid = ovalid_q;
	assign out.data.removed_node = ro_node_q;
	assign out.data.removed_cost = ro_cost_q;
	assign out.data.heap_empty = ro_emp_q;
	assign out.data.rejected = ro_rej_q;

	`IMH_ASSERT_IMP(a_no_accept_busy, clk, arst_n, st_q != ST_IDLE, !in.ready)
	`IMH_ASSERT_NEXT(a_done_gives_item, clk, arst_n, st_q == ST_DONE && init_q, out.valid)
	`IMH_ASSERT_NEXT(a_held_until_taken, clk, arst_n, out.valid && !out.ready, out.valid)
endmodule
